// ----- rtl/wavgs_pkg.sv -----
// ----------------------------------------------------------------------------
// wavgs_pkg
// Shared widths and register map for the windowed average with stability core.
// ----------------------------------------------------------------------------
package wavgs_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int DEV_W     = 16;
  localparam int ALLOW_W   = 5;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 4;
  localparam int REG_IDX_W = 2;
  localparam int OUT_DW    = 24;

  // register indexes, byte address = 4 * index
  localparam logic [REG_IDX_W-1:0] REG_REF_LEVEL  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEVIATION  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_OUTLIERS   = 2'd2;

  function automatic logic [SAMPLE_W:0] abs_diff(input logic signed [SAMPLE_W-1:0] a,
                                                 input logic signed [SAMPLE_W-1:0] b);
    logic signed [SAMPLE_W:0] d;
    d = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
    abs_diff = d[SAMPLE_W] ? -d : d;
  endfunction

endpackage

// ----- rtl/windowed_average_with_stability_core.sv -----
// ----------------------------------------------------------------------------
// windowed_average_with_stability_core
// Each sample enters a circular window of WINDOW_LEN entries; the block
// returns the mean of the held samples (sum over fill count until the window
// is full, over WINDOW_LEN after), truncated toward zero, with a full flag and
// a stable flag (full, and no more than allowed_outliers entries whose
// |sample - reference_level| exceeded allowed_deviation when written). One
// sample is taken at a time: it passes through the UPDATE, DIVIDE and FINISH
// states, where a restoring divider produces the MAG_W-bit quotient (MAG_W =
// 15 + number of bits to hold WINDOW_LEN) one quotient bit per cycle; FINISH
// waits while the output is stalled, and the next sample is taken once the
// result is registered and the block is back in IDLE. A finished result sits
// in the output register while the next sample is accepted. No clearing pass
// is needed after reset. The user must write configuration through the APB
// port only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module windowed_average_with_stability_core
  import wavgs_pkg::*;
#(
  parameter int WINDOW_LEN = 16
) (
  input  logic                clk,
  input  logic                rst,
  // APB configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  // input stream; s_tdata[15:0] = sample
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [SAMPLE_W-1:0] s_tdata,
  // output stream; m_tdata[15:0] = mean_value, [16] = window_full,
  // [17] = window_stable, [23:18] = 0
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_DW-1:0]   m_tdata
);

  localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
  localparam int IDX_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int SUM_W  = SAMPLE_W + CNT_W;
  localparam int MAG_W  = SUM_W - 1;
  localparam int DCNT_W = $clog2(MAG_W);
  localparam int CMP_W  = (CNT_W > ALLOW_W) ? CNT_W : ALLOW_W;

  typedef enum logic [1:0] {IDLE, UPDATE, DIVIDE, FINISH} state_t;

  state_t state;

  // configuration
  logic signed [SAMPLE_W-1:0] reference_level;
  logic [DEV_W-1:0]           allowed_deviation;
  logic [ALLOW_W-1:0]         allowed_outliers;

  // window storage
  logic signed [SAMPLE_W-1:0] sample_store [WINDOW_LEN];
  logic                       outlier_marks [WINDOW_LEN];

  logic signed [SUM_W-1:0]    running_sum;
  logic [IDX_W-1:0]           write_slot;
  logic                       filled_once;
  logic [CNT_W-1:0]           outlier_count;

  // per-item working registers
  logic signed [SAMPLE_W-1:0] new_sample;
  logic                       new_mark;
  logic signed [SAMPLE_W-1:0] old_sample;
  logic                       old_mark;

  // divider
  logic [MAG_W-1:0]           quo;
  logic [CNT_W-1:0]           rem;
  logic [CNT_W-1:0]           divisor;
  logic                       neg;
  logic [DCNT_W-1:0]          div_cnt;

  logic                       cfg_wr;
  logic [REG_IDX_W-1:0]       reg_idx;
  logic                       in_acc;
  logic                       out_free;
  logic                       mark_calc;
  logic signed [SUM_W-1:0]    sum_next;
  logic [CNT_W-1:0]           count_next;
  logic [CNT_W:0]             rem_sh;
  logic [CNT_W:0]             rem_sub;
  logic                       ge;
  logic [SAMPLE_W-1:0]        mean_mag;
  logic [SAMPLE_W-1:0]        mean_val;
  logic                       stable;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[APB_AW-1:2];
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign s_tready = (state == IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign mark_calc = abs_diff(s_tdata, reference_level) > {1'b0, allowed_deviation};

  always_comb begin
    sum_next = running_sum + {{(SUM_W-SAMPLE_W){new_sample[SAMPLE_W-1]}}, new_sample};
    count_next = outlier_count + CNT_W'(new_mark);
    if (filled_once) begin
      sum_next = sum_next - {{(SUM_W-SAMPLE_W){old_sample[SAMPLE_W-1]}}, old_sample};
      count_next = count_next - CNT_W'(old_mark);
    end
  end

  assign rem_sh  = {rem, quo[MAG_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign ge      = rem_sh >= {1'b0, divisor};

  assign mean_mag = quo[SAMPLE_W-1:0];
  assign mean_val = neg ? -mean_mag : mean_mag;
  assign stable   = filled_once &&
                    (CMP_W'(outlier_count) <= CMP_W'(allowed_outliers));

  always_comb begin
    case (reg_idx)
      REG_REF_LEVEL: prdata = {{(APB_DW-SAMPLE_W){reference_level[SAMPLE_W-1]}},
                               reference_level};
      REG_DEVIATION: prdata = {{(APB_DW-DEV_W){1'b0}}, allowed_deviation};
      REG_OUTLIERS:  prdata = {{(APB_DW-ALLOW_W){1'b0}}, allowed_outliers};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_level   <= '0;
      allowed_deviation <= '0;
      allowed_outliers  <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_REF_LEVEL: reference_level   <= pwdata[SAMPLE_W-1:0];
        REG_DEVIATION: allowed_deviation <= pwdata[DEV_W-1:0];
        REG_OUTLIERS:  allowed_outliers  <= pwdata[ALLOW_W-1:0];
        default: ;
      endcase
    end
  end

  // window memory: read old entry on accept, overwrite it in UPDATE
  always_ff @(posedge clk) begin
    if (in_acc) begin
      old_sample <= sample_store[write_slot];
      old_mark   <= outlier_marks[write_slot];
    end
    if (state == UPDATE) begin
      sample_store[write_slot]  <= new_sample;
      outlier_marks[write_slot] <= new_mark;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      running_sum   <= '0;
      write_slot    <= '0;
      filled_once   <= 1'b0;
      outlier_count <= '0;
      m_tvalid      <= 1'b0;
      div_cnt       <= '0;
    end else begin
      if (state == FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_acc) begin
            new_sample <= s_tdata;
            new_mark   <= mark_calc;
            state      <= UPDATE;
          end
        end
        UPDATE: begin
          running_sum   <= sum_next;
          outlier_count <= count_next;
          neg           <= sum_next[SUM_W-1];
          quo           <= sum_next[SUM_W-1] ? MAG_W'(-sum_next) : MAG_W'(sum_next);
          rem           <= '0;
          div_cnt       <= '0;
          if (write_slot == IDX_W'(WINDOW_LEN - 1)) begin
            write_slot  <= '0;
            filled_once <= 1'b1;
            divisor     <= CNT_W'(WINDOW_LEN);
          end else begin
            write_slot  <= write_slot + 1'b1;
            divisor     <= filled_once ? CNT_W'(WINDOW_LEN)
                                       : CNT_W'(write_slot) + 1'b1;
          end
          state <= DIVIDE;
        end
        DIVIDE: begin
          quo     <= {quo[MAG_W-2:0], ge};
          rem     <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DCNT_W'(MAG_W - 1)) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (out_free) begin
            m_tdata  <= {{(OUT_DW-SAMPLE_W-2){1'b0}}, stable, filled_once, mean_val};
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // ------------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    outlier_count <= CNT_W'(WINDOW_LEN))
    else $error("outlier count exceeds window length");

  a_count_fill: assert property (@(posedge clk) disable iff (rst)
    !filled_once |-> (outlier_count <= CNT_W'(write_slot)))
    else $error("outlier count exceeds fill level before window full");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !s_tready)
    else $error("input accepted while previous sample in progress");

  a_div_range: assert property (@(posedge clk) disable iff (rst)
    (state == DIVIDE) |-> (divisor != '0) && (div_cnt <= DCNT_W'(MAG_W - 1)))
    else $error("divider state out of range");

endmodule
